FILE: rtl/twst_pkg.sv
// Package for the text word statistics block: constants, codes and control structs.
package twst_pkg;

  localparam int MAX_WORD_LEN_DEF = 20;
  localparam int LETTER_BINS      = 26;
  localparam int DIGIT_BINS       = 10;

  // Byte codes that the decoder tests against.
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] PUNCT_A_LO  = 8'd33;
  localparam logic [7:0] PUNCT_A_HI  = 8'd47;
  localparam logic [7:0] DIGIT_LO    = 8'd48;
  localparam logic [7:0] DIGIT_HI    = 8'd57;
  localparam logic [7:0] PUNCT_B_LO  = 8'd58;
  localparam logic [7:0] PUNCT_B_HI  = 8'd64;
  localparam logic [7:0] UPPER_LO    = 8'd65;
  localparam logic [7:0] UPPER_HI    = 8'd90;
  localparam logic [7:0] LOWER_LO    = 8'd97;
  localparam logic [7:0] LOWER_HI    = 8'd122;

  // Result kinds.
  localparam logic [2:0] KIND_LENGTH   = 3'd0;
  localparam logic [2:0] KIND_OVERFLOW = 3'd1;
  localparam logic [2:0] KIND_LETTER   = 3'd2;
  localparam logic [2:0] KIND_DIGIT    = 3'd3;
  localparam logic [2:0] KIND_TOTAL    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // an input item is taken this cycle
    logic upd_wr;     // write the incremented counter back
    logic dump_sel;   // counter memory is addressed by the dump pointer
    logic dump_load;  // load the output register from the memory
    logic tot_load;   // load the word total and clear all counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eot;        // the offered item is an end of text
    logic inc_req;    // the offered item needs a counter increment
    logic last_ptr;   // the dump pointer is at the last memory entry
    logic out_free;   // the output register can take a result this cycle
  } sts_t;

endpackage

FILE: rtl/twst_in_if.sv
// Input channel interface: one text byte or end-of-text marker per item.
interface twst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: rtl/twst_out_if.sv
// Result channel interface: one counter of the dump per item.
interface twst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  bin_kind;
  logic [4:0]  bin_index;
  logic [31:0] bin_count;
  logic        last_of_dump;

  modport source (output valid, output bin_kind, output bin_index, output bin_count,
                  output last_of_dump, input ready);
  modport sink (input valid, input bin_kind, input bin_index, input bin_count,
                input last_of_dump, output ready);
endinterface

FILE: rtl/twst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 58
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/twst_ctrl.sv
// Controller state machine: sequences counter updates and the end-of-text dump.
module twst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  twst_pkg::sts_t sts,
  output twst_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DRD  = 3'd2;
  localparam logic [2:0] S_DOUT = 3'd3;
  localparam logic [2:0] S_DTOT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       eot_pend_r, eot_pend_nxt;

  always_comb begin
    state_nxt    = state_r;
    eot_pend_nxt = eot_pend_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          eot_pend_nxt = sts.eot;
          if (sts.inc_req) begin
            state_nxt = S_UPD;
          end else if (sts.eot) begin
            state_nxt = S_DRD;
          end
        end
      end
      S_UPD: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = eot_pend_r ? S_DRD : S_IDLE;
      end
      S_DRD: begin
        cmd.dump_sel = 1'b1;
        state_nxt    = S_DOUT;
      end
      S_DOUT: begin
        cmd.dump_sel = 1'b1;
        if (sts.out_free) begin
          cmd.dump_load = 1'b1;
          state_nxt     = sts.last_ptr ? S_DTOT : S_DRD;
        end
      end
      S_DTOT: begin
        if (sts.out_free) begin
          cmd.tot_load = 1'b1;
          eot_pend_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      eot_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      eot_pend_r <= eot_pend_nxt;
    end
  end

endmodule

FILE: rtl/twst_dp.sv
// Datapath: byte decoder, word state, counter memory and output register.
module twst_dp #(
  parameter int MAX_WORD_LEN = twst_pkg::MAX_WORD_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  input  logic [7:0]     in_text_byte,
  input  logic           in_end_of_text,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [2:0]     out_bin_kind,
  output logic [4:0]     out_bin_index,
  output logic [31:0]    out_bin_count,
  output logic           out_last_of_dump,
  input  twst_pkg::cmd_t cmd,
  output twst_pkg::sts_t sts
);

  // Memory layout follows dump order: length bins, overflow, letters, digits.
  localparam int OVF_ADDR = MAX_WORD_LEN;
  localparam int LET_BASE = MAX_WORD_LEN + 1;
  localparam int DIG_BASE = LET_BASE + twst_pkg::LETTER_BINS;
  localparam int DEPTH    = DIG_BASE + twst_pkg::DIGIT_BINS;
  localparam int AW       = $clog2(DEPTH);
  localparam int LW       = $clog2(MAX_WORD_LEN + 2);

  logic          skip_r;
  logic [LW-1:0] open_len_r;
  logic [31:0]   word_total_r;
  logic [DEPTH-1:0] valid_r;
  logic          rd_valid_r;
  logic [AW-1:0] upd_addr_r;
  logic [AW-1:0] ptr_r;
  logic          out_valid_r;
  logic [2:0]    kind_r;
  logic [4:0]    index_r;
  logic [31:0]   count_r;
  logic          last_r;

  logic [AW-1:0] dec_addr;
  logic [AW-1:0] rd_addr;
  logic          inc_req, flush, grow, start_word;
  logic          is_ws, is_punct, is_digit, is_upper, is_lower;
  logic [31:0]   rd_data, cur_count, wr_count;
  logic [2:0]    dump_kind;
  logic [4:0]    dump_index;

  always_comb begin
    is_ws    = (in_text_byte == twst_pkg::CH_SPACE) || (in_text_byte == twst_pkg::CH_TAB)
               || (in_text_byte == twst_pkg::CH_NL);
    is_punct = (in_text_byte >= twst_pkg::PUNCT_A_LO && in_text_byte <= twst_pkg::PUNCT_A_HI)
               || (in_text_byte >= twst_pkg::PUNCT_B_LO && in_text_byte <= twst_pkg::PUNCT_B_HI);
    is_digit = in_text_byte >= twst_pkg::DIGIT_LO && in_text_byte <= twst_pkg::DIGIT_HI;
    is_upper = in_text_byte >= twst_pkg::UPPER_LO && in_text_byte <= twst_pkg::UPPER_HI;
    is_lower = in_text_byte >= twst_pkg::LOWER_LO && in_text_byte <= twst_pkg::LOWER_HI;

    inc_req    = 1'b0;
    flush      = 1'b0;
    grow       = 1'b0;
    start_word = 1'b0;
    dec_addr   = '0;
    if (in_end_of_text || is_ws) begin
      // Close the open word into its length bin or the overflow bin.
      flush   = 1'b1;
      inc_req = (open_len_r != '0);
      if (open_len_r <= LW'(MAX_WORD_LEN)) begin
        dec_addr = AW'(open_len_r - 1'b1);
      end else begin
        dec_addr = AW'(OVF_ADDR);
      end
    end else if (skip_r && is_punct) begin
      inc_req = 1'b0;
    end else if (skip_r && is_digit) begin
      inc_req  = 1'b1;
      dec_addr = AW'(DIG_BASE) + AW'(in_text_byte - twst_pkg::DIGIT_LO);
    end else begin
      grow = 1'b1;
      if (open_len_r == '0) begin
        start_word = 1'b1;
        if (is_upper) begin
          inc_req  = 1'b1;
          dec_addr = AW'(LET_BASE) + AW'(in_text_byte - twst_pkg::UPPER_LO);
        end else if (is_lower) begin
          inc_req  = 1'b1;
          dec_addr = AW'(LET_BASE) + AW'(in_text_byte - twst_pkg::LOWER_LO);
        end
      end
    end
  end

  assign rd_addr   = cmd.dump_sel ? ptr_r : dec_addr;
  assign cur_count = rd_valid_r ? rd_data : 32'd0;
  assign wr_count  = (&cur_count) ? cur_count : cur_count + 32'd1;

  twst_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.upd_wr),
    .waddr (upd_addr_r),
    .wdata (wr_count),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    if (ptr_r < AW'(OVF_ADDR)) begin
      dump_kind  = twst_pkg::KIND_LENGTH;
      dump_index = 5'(ptr_r) + 5'd1;
    end else if (ptr_r == AW'(OVF_ADDR)) begin
      dump_kind  = twst_pkg::KIND_OVERFLOW;
      dump_index = 5'd0;
    end else if (ptr_r < AW'(DIG_BASE)) begin
      dump_kind  = twst_pkg::KIND_LETTER;
      dump_index = 5'(ptr_r - AW'(LET_BASE));
    end else begin
      dump_kind  = twst_pkg::KIND_DIGIT;
      dump_index = 5'(ptr_r - AW'(DIG_BASE));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r       <= 1'b0;
      open_len_r   <= '0;
      word_total_r <= '0;
      valid_r      <= '0;
      ptr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
      if (cmd.accept) begin
        if (flush) begin
          open_len_r <= '0;
        end else if (grow && open_len_r <= LW'(MAX_WORD_LEN)) begin
          open_len_r <= open_len_r + 1'b1;
        end
        if (start_word && !(&word_total_r)) begin
          word_total_r <= word_total_r + 32'd1;
        end
      end
      if (cmd.upd_wr) begin
        valid_r[upd_addr_r] <= 1'b1;
      end
      if (cmd.dump_load) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.tot_load) begin
        word_total_r <= '0;
        open_len_r   <= '0;
        valid_r      <= '0;
        ptr_r        <= '0;
      end
      if (cmd.dump_load || cmd.tot_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r <= valid_r[rd_addr];
    if (cmd.accept) begin
      upd_addr_r <= dec_addr;
    end
    if (cmd.dump_load) begin
      kind_r  <= dump_kind;
      index_r <= dump_index;
      count_r <= cur_count;
      last_r  <= 1'b0;
    end else if (cmd.tot_load) begin
      kind_r  <= twst_pkg::KIND_TOTAL;
      index_r <= 5'd0;
      count_r <= word_total_r;
      last_r  <= 1'b1;
    end
  end

  assign sts.eot      = in_end_of_text;
  assign sts.inc_req  = inc_req;
  assign sts.last_ptr = (ptr_r == AW'(DEPTH - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_bin_kind     = kind_r;
  assign out_bin_index    = index_r;
  assign out_bin_count    = count_r;
  assign out_last_of_dump = last_r;

endmodule

FILE: rtl/text_word_statistics.sv
// Top level of the text word statistics block: word-length, letter and digit histogram.
//
// Usage: text arrives on in_item, one byte per item, with end_of_text low. Space, tab and
// newline close the word in progress; its length is counted in a bin for 1 to MAX_WORD_LEN
// or in the overflow bin. The first byte of a word counts the word and, if it is a letter,
// the letter of either case. cfg_wr_en with cfg_wr_data sets skip mode, which drops the
// punctuation bytes and counts digits on their own; write it only while the block is idle.
// A byte that changes no memory counter leaves the block ready for the next item; one
// that bumps a counter blocks the input during a write-back state, since the increment
// is a read-modify-write on the single write port of the counter memory. An item with
// end_of_text high closes the open word and then dumps MAX_WORD_LEN + 38 results on
// out_item, in order length bins, overflow, letters A to Z, digits 0 to 9 and finally
// the word total with last_of_dump set. The dump walks the counter memory one result at
// a time, in a read state that sets the address and then an output state that loads the
// registered read data. When out_item.ready is low the walk simply holds; the input stays
// blocked until the total has been loaded, after which all counters are cleared and new
// text is taken while the last result may still wait in the output register.
// Reset (rst_n low, synchronous) clears skip mode and marks every counter entry empty
// through per-entry valid flags, so no clearing pass is needed.
module text_word_statistics #(
  parameter int MAX_WORD_LEN = twst_pkg::MAX_WORD_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  twst_in_if.sink          in_item,
  twst_out_if.source       out_item
);

  twst_pkg::cmd_t cmd;
  twst_pkg::sts_t sts;
  logic           in_ready;

  // The controller decides when an item is taken and walks the dump.
  twst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the counters, the open word and the output register.
  twst_dp #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_text_byte     (in_item.text_byte),
    .in_end_of_text   (in_item.end_of_text),
    .out_ready        (out_item.ready),
    .out_valid        (out_item.valid),
    .out_bin_kind     (out_item.bin_kind),
    .out_bin_index    (out_item.bin_index),
    .out_bin_count    (out_item.bin_count),
    .out_last_of_dump (out_item.last_of_dump),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign in_item.ready = in_ready;

  // While the dump walks the memory, no new input item may be taken.
  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_sel |-> !in_item.ready)
    else $error("input taken during dump");

  // An end-of-text item always makes the block busy in the next cycle.
  a_eot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready && in_item.end_of_text) |=> !in_item.ready)
    else $error("block ready right after end of text");

  // A counter write-back only follows an accepted item.
  a_upd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> $past(in_item.valid && in_item.ready))
    else $error("counter update without an accepted item");

  // The last result of a dump is always the word total.
  a_last_is_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.last_of_dump) |-> (out_item.bin_kind == twst_pkg::KIND_TOTAL))
    else $error("last result is not the word total");

endmodule

FILE: bench/twst_checker.sv
// Checker for the text word statistics block: predicts every dumped counter and compares it.
`timescale 1ns / 1ps

module twst_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  twst_in_if   in_mon,
  twst_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);
  import twst_pkg::*;

  localparam int MAX_LEN = MAX_WORD_LEN_DEF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  index;
    logic [31:0] count;
    logic        last;
  } bin_result_t;

  // Predicted histogram state; entry 0 of the length tally is the overflow bin.
  logic [31:0] length_tally [0:MAX_LEN];
  logic [31:0] letter_tally [0:LETTER_BINS-1];
  logic [31:0] digit_tally  [0:DIGIT_BINS-1];
  logic [31:0] words_seen;
  int          open_len;
  logic        skip_punct;

  bin_result_t dump_q [$];
  int          fail_total = 0;

  function automatic logic [31:0] bumped(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function void clear_tallies();
    for (int i = 0; i <= MAX_LEN; i++) length_tally[i] = '0;
    for (int i = 0; i < LETTER_BINS; i++) letter_tally[i] = '0;
    for (int i = 0; i < DIGIT_BINS; i++) digit_tally[i] = '0;
    words_seen = '0;
    open_len = 0;
  endfunction

  function void close_word();
    if (open_len != 0) begin
      if (open_len <= MAX_LEN) begin
        length_tally[open_len] = bumped(length_tally[open_len]);
      end else begin
        length_tally[0] = bumped(length_tally[0]);
      end
      open_len = 0;
    end
  endfunction

  function void take_byte(input logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB || b == CH_NL) begin
      close_word();
      return;
    end
    if (skip_punct) begin
      if ((b >= PUNCT_A_LO && b <= PUNCT_A_HI) || (b >= PUNCT_B_LO && b <= PUNCT_B_HI)) begin
        return;
      end
      if (b >= DIGIT_LO && b <= DIGIT_HI) begin
        digit_tally[b - DIGIT_LO] = bumped(digit_tally[b - DIGIT_LO]);
        return;
      end
    end
    if (open_len == 0) begin
      words_seen = bumped(words_seen);
      if (b >= UPPER_LO && b <= UPPER_HI) begin
        letter_tally[b - UPPER_LO] = bumped(letter_tally[b - UPPER_LO]);
      end else if (b >= LOWER_LO && b <= LOWER_HI) begin
        letter_tally[b - LOWER_LO] = bumped(letter_tally[b - LOWER_LO]);
      end
    end
    // The open length stops one past the largest bin, which is still an overflow word.
    if (open_len <= MAX_LEN) open_len++;
  endfunction

  function void dump_tallies();
    close_word();
    for (int i = 1; i <= MAX_LEN; i++) begin
      dump_q.push_back(bin_result_t'{KIND_LENGTH, 5'(i), length_tally[i], 1'b0});
    end
    dump_q.push_back(bin_result_t'{KIND_OVERFLOW, 5'd0, length_tally[0], 1'b0});
    for (int i = 0; i < LETTER_BINS; i++) begin
      dump_q.push_back(bin_result_t'{KIND_LETTER, 5'(i), letter_tally[i], 1'b0});
    end
    for (int i = 0; i < DIGIT_BINS; i++) begin
      dump_q.push_back(bin_result_t'{KIND_DIGIT, 5'(i), digit_tally[i], 1'b0});
    end
    dump_q.push_back(bin_result_t'{KIND_TOTAL, 5'd0, words_seen, 1'b1});
    clear_tallies();
  endfunction

  // Results are compared before the input is applied, since a result taken in the same
  // cycle always belongs to an earlier dump.
  always @(posedge clk) begin : watch
    bin_result_t want;
    if (!rst_n) begin
      clear_tallies();
      skip_punct = 1'b0;
      dump_q.delete();
    end else begin
      if (cfg_wr_en) skip_punct = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) begin
        if (dump_q.size() == 0) begin
          fail_total++;
          $error("unexpected counter result: kind %0d index %0d count %0d",
                 out_mon.bin_kind, out_mon.bin_index, out_mon.bin_count);
        end else begin
          want = dump_q.pop_front();
          if (out_mon.bin_kind !== want.kind) begin
            fail_total++;
            $error("bin_kind: expected %0d, got %0d", want.kind, out_mon.bin_kind);
          end
          if (out_mon.bin_index !== want.index) begin
            fail_total++;
            $error("bin_index: expected %0d, got %0d", want.index, out_mon.bin_index);
          end
          if (out_mon.bin_count !== want.count) begin
            fail_total++;
            $error("bin_count: expected %0d, got %0d", want.count, out_mon.bin_count);
          end
          if (out_mon.last_of_dump !== want.last) begin
            fail_total++;
            $error("last_of_dump: expected %0d, got %0d", want.last, out_mon.last_of_dump);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.end_of_text) begin
          dump_tallies();
        end else begin
          take_byte(in_mon.text_byte);
        end
      end
    end
    fail_count    <= fail_total;
    pending_count <= dump_q.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the text word statistics bench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb;
  import twst_pkg::*;

  localparam int MAX_LEN          = MAX_WORD_LEN_DEF;
  localparam int DUMP_LEN         = MAX_WORD_LEN_DEF + 38;
  localparam int CYCLE_LIMIT      = 2000000;
  localparam int ITEMS_PER_PHASE  = 40;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  // The directed part ends with three dumps, so the receiver's long hold-off lands on the
  // first dump of the random part, which is always followed by more text. It starts once the
  // first result of that dump has been taken, so the rest of the dump is held back.
  localparam int HOLD_AFTER_RESULTS = 3 * DUMP_LEN;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   send_calm = 0;

  twst_in_if  in_ch ();
  twst_out_if out_ch ();

  text_word_statistics u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_ch),
    .out_item    (out_ch)
  );

  twst_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off if the block stops making progress.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Idle lengths shared by both sides: mostly none or a few cycles, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A text byte drawn from the classes that the block treats differently: letters of both
  // cases, digits, the two punctuation ranges, other printable bytes, high bytes and any byte.
  function automatic logic [7:0] text_byte_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'($urandom_range(UPPER_LO, UPPER_HI));
    if (r < 40) return 8'($urandom_range(LOWER_LO, LOWER_HI));
    if (r < 55) return 8'($urandom_range(DIGIT_LO, DIGIT_HI));
    if (r < 63) return 8'($urandom_range(PUNCT_A_LO, PUNCT_A_HI));
    if (r < 70) return 8'($urandom_range(PUNCT_B_LO, PUNCT_B_HI));
    if (r < 78) return 8'($urandom_range(UPPER_HI + 1, LOWER_LO - 1));
    if (r < 82) return 8'($urandom_range(LOWER_HI + 1, 127));
    if (r < 92) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] separator_pick();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  // Offers one item and returns at the clock edge where it is taken. Valid stays high
  // between back-to-back items; a gap lowers it in an earlier time step than it rises again.
  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = idle_length();
      if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops the sender and waits until every dumped counter has come out. A byte leaves no
  // result behind, so a few more cycles let a pending counter update finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_skip_mode(input logic mode);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random text: words of random length and content split by runs of whitespace. Most words
  // are short, some reach the largest length bin and some overflow it far enough to pin the
  // open length. An end of text now and then dumps in the middle of a word; one more falls
  // halfway through and one closes the phase.
  task automatic send_random_text(input int budget);
    int   sent;
    int   len;
    int   r;
    logic mid_done;
    sent     = 0;
    mid_done = 1'b0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, 6);
      end else if (r < 85) begin
        len = $urandom_range(7, MAX_LEN);
      end else begin
        len = $urandom_range(MAX_LEN + 1, MAX_LEN + 10);
      end
      repeat (len) begin
        send_item(text_byte_pick(), 1'b0);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
      repeat ($urandom_range(0, 2)) begin
        send_item(separator_pick(), 1'b0);
        sent++;
      end
      if (!mid_done && sent >= budget / 2) begin
        mid_done = 1'b1;
        send_item(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: random stalls of mixed length with calm stretches in between, plus one long
  // hold-off at the start of a dump while the sender keeps offering text behind it.
  initial begin : receiver
    int   gap_left;
    int   calm_left;
    int   hold_left;
    int   taken;
    logic hold_done;
    gap_left     = 0;
    calm_left    = 0;
    hold_left    = 0;
    taken        = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && taken > HOLD_AFTER_RESULTS && out_ch.valid) begin
        hold_done    = 1'b1;
        hold_left    = LONG_HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          gap_left = idle_length();
          if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 80);
        end
      end
    end
  end

  // Stimulus: directed text in both modes, then three random phases that switch the mode.
  initial begin : stimulus
    logic [7:0] plain_text [];
    logic [7:0] skip_text [];
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    rst_n             = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Without skip mode: a tab with no word open, words bounded by the letters A, Z, a and
    // z, a word that starts with a digit and holds a high byte, and a word left open that
    // the end of text has to close. A second end of text then dumps all-zero counters.
    plain_text = '{CH_TAB, UPPER_LO, UPPER_HI, CH_NL, LOWER_LO, LOWER_HI, CH_SPACE,
                   DIGIT_LO, 8'hFF, CH_SPACE, UPPER_HI + 8'd1};
    write_skip_mode(1'b0);
    foreach (plain_text[i]) send_item(plain_text[i], 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);

    // With skip mode: both punctuation ranges at their edges vanish, digits count on
    // their own even inside a word, and a byte below lower case and a high byte form a word.
    skip_text = '{PUNCT_A_LO, PUNCT_A_HI, PUNCT_B_LO, PUNCT_B_HI, DIGIT_LO, DIGIT_HI,
                  LOWER_LO + 8'd1, DIGIT_LO + 8'd3, CH_SPACE, LOWER_LO - 8'd1, 8'h80, CH_NL};
    write_skip_mode(1'b1);
    foreach (skip_text[i]) send_item(skip_text[i], 1'b0);
    send_item(8'h55, 1'b1);

    send_random_text(ITEMS_PER_PHASE);
    write_skip_mode(1'b0);
    send_random_text(ITEMS_PER_PHASE);
    write_skip_mode(1'b1);
    send_random_text(ITEMS_PER_PHASE);

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/twst_pkg.sv
rtl/twst_in_if.sv
rtl/twst_out_if.sv
rtl/twst_ram.sv
rtl/twst_ctrl.sv
rtl/twst_dp.sv
rtl/text_word_statistics.sv
bench/twst_checker.sv
bench/tb.sv
